>>> rtl/fvn_pkg.sv
// shared constants, types and helper functions for the fbm value noise cloud pixel unit
`default_nettype none

package fvn_pkg;

    localparam int COORD_BITS  = 8;
    localparam int MAX_OCTAVES = 8;
    localparam int FRAC_BITS   = 16;

    localparam int OCT_W     = 4;
    localparam int SCALE_W   = 3;
    localparam int OCT_IDX_W = $clog2(MAX_OCTAVES);
    localparam int SHIFT_W   = COORD_BITS + MAX_OCTAVES - 1;
    localparam int FMASK_W   = (1 << SCALE_W) - 1;
    localparam int WEIGHT_W  = FRAC_BITS + 1;
    localparam int NOISE_W   = 17;
    localparam int CONTRIB_W = NOISE_W + 1;
    localparam int SUM_W     = 20;
    localparam int RECIP_W   = 17;
    localparam int UNIT_W    = FRAC_BITS + 1;
    localparam int GRAY_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam int LANE_LAT   = 7;
    localparam int TREE_LAT   = 3;
    localparam int SQRT_STEPS = UNIT_W;
    localparam int POST_LAT   = SQRT_STEPS + 4;
    localparam int PIPE_LAT   = 1 + LANE_LAT + TREE_LAT + POST_LAT;

    localparam logic [31:0] HASH_K1 = 32'd374761393;
    localparam logic [31:0] HASH_K2 = 32'd668265263;
    localparam logic [31:0] HASH_K3 = 32'd1274126177;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OCTAVES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SCALE   = 2'd1;

    localparam logic [OCT_W-1:0]   RST_OCTAVES = 4'd4;
    localparam logic [SCALE_W-1:0] RST_SCALE   = 3'd5;

    typedef logic signed [CONTRIB_W-1:0] t_contrib;
    typedef logic signed [SUM_W-1:0]     t_sum;

    // h ^ (h >>> 13)
    function automatic logic [31:0] hash_mix(input logic [31:0] h);
        hash_mix = h ^ 32'($signed(h) >>> 13);
    endfunction

    // (m >> 15) - 32768 is the top 16 bits of the low 31 with the msb flipped
    function automatic logic signed [15:0] corner_val(input logic [31:0] g);
        corner_val = $signed({~g[30], g[29:15]});
    endfunction

    // round(2^(n+15) / (2^n - 1)) in Q.16
    function automatic logic [RECIP_W-1:0] recip_lookup(input logic [OCT_W-1:0] n);
        case (n)
            4'd1:    recip_lookup = 17'd65536;
            4'd2:    recip_lookup = 17'd43691;
            4'd3:    recip_lookup = 17'd37449;
            4'd4:    recip_lookup = 17'd34953;
            4'd5:    recip_lookup = 17'd33825;
            4'd6:    recip_lookup = 17'd33288;
            4'd7:    recip_lookup = 17'd33026;
            4'd8:    recip_lookup = 17'd32897;
            default: recip_lookup = 17'd65536;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> rtl/fvn_octave_lane.sv
// one noise octave: lattice split, corner hashing, smoothstep and bilinear blend
`default_nettype none

module fvn_octave_lane (
    input  wire                            i_clk,
    input  wire [fvn_pkg::COORD_BITS-1:0]  i_x,
    input  wire [fvn_pkg::COORD_BITS-1:0]  i_y,
    input  wire [fvn_pkg::SCALE_W-1:0]     i_scale,
    input  wire [fvn_pkg::OCT_IDX_W-1:0]   i_octave,
    input  wire                            i_enable,
    output logic signed [fvn_pkg::CONTRIB_W-1:0] o_contrib
);
    import fvn_pkg::*;

    logic [SHIFT_W-1:0]   xs, ys, cx, cy;
    logic [FMASK_W-1:0]   fmask;
    logic [FRAC_BITS-1:0] fx, fy;

    // stage 1
    logic [31:0]          r1_p, r1_q;
    logic [FRAC_BITS-1:0] r1_fx2, r1_fy2;
    logic [FRAC_BITS+1:0] r1_tx, r1_ty;
    // stage 2
    logic [31:0]          r2_h00, r2_h10, r2_h01, r2_h11;
    logic [WEIGHT_W-1:0]  r2_wx, r2_wy;
    logic [33:0]          wx_full, wy_full;
    // stage 3
    logic [31:0]          r3_g00, r3_g10, r3_g01, r3_g11;
    logic [WEIGHT_W-1:0]  r3_wx, r3_wy;
    // stage 4
    logic signed [15:0]   v00, v10, v01, v11;
    logic signed [16:0]   dx0, dx1;
    logic signed [17:0]   wxs;
    logic signed [34:0]   r4_d0, r4_d1;
    logic signed [15:0]   r4_v00, r4_v01;
    logic [WEIGHT_W-1:0]  r4_wy;
    // stage 5
    logic signed [34:0]   t_top, t_bot;
    logic signed [NOISE_W-1:0] r5_top, r5_bot;
    logic [WEIGHT_W-1:0]  r5_wy;
    // stage 6
    logic signed [17:0]   dy;
    logic signed [35:0]   r6_prod;
    logic signed [NOISE_W-1:0] r6_top;
    // stage 7
    logic signed [35:0]   t_nz;
    logic signed [NOISE_W-1:0] nz;
    logic signed [CONTRIB_W-1:0] contrib;

    assign xs    = SHIFT_W'(i_x) << i_octave;
    assign ys    = SHIFT_W'(i_y) << i_octave;
    assign cx    = xs >> i_scale;
    assign cy    = ys >> i_scale;
    assign fmask = FMASK_W'(((FMASK_W + 1)'(1)) << i_scale) - FMASK_W'(1);
    assign fx    = FRAC_BITS'(xs[FMASK_W-1:0] & fmask) << (5'(FRAC_BITS) - 5'(i_scale));
    assign fy    = FRAC_BITS'(ys[FMASK_W-1:0] & fmask) << (5'(FRAC_BITS) - 5'(i_scale));

    always_ff @(posedge i_clk) begin
        r1_p   <= 32'(32'(cx) * HASH_K1);
        r1_q   <= 32'(32'(cy) * HASH_K2);
        r1_fx2 <= FRAC_BITS'((32'(fx) * 32'(fx)) >> FRAC_BITS);
        r1_fy2 <= FRAC_BITS'((32'(fy) * 32'(fy)) >> FRAC_BITS);
        r1_tx  <= (FRAC_BITS + 2)'(3 << FRAC_BITS) - {1'b0, fx, 1'b0};
        r1_ty  <= (FRAC_BITS + 2)'(3 << FRAC_BITS) - {1'b0, fy, 1'b0};
    end

    assign wx_full = 34'(r1_fx2) * 34'(r1_tx);
    assign wy_full = 34'(r1_fy2) * 34'(r1_ty);

    // neighbor cells only add the hash constants
    always_ff @(posedge i_clk) begin
        r2_h00 <= hash_mix(r1_p + r1_q);
        r2_h10 <= hash_mix(r1_p + r1_q + HASH_K1);
        r2_h01 <= hash_mix(r1_p + r1_q + HASH_K2);
        r2_h11 <= hash_mix(r1_p + r1_q + HASH_K1 + HASH_K2);
        r2_wx  <= WEIGHT_W'(wx_full >> FRAC_BITS);
        r2_wy  <= WEIGHT_W'(wy_full >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        r3_g00 <= 32'(r2_h00 * HASH_K3);
        r3_g10 <= 32'(r2_h10 * HASH_K3);
        r3_g01 <= 32'(r2_h01 * HASH_K3);
        r3_g11 <= 32'(r2_h11 * HASH_K3);
        r3_wx  <= r2_wx;
        r3_wy  <= r2_wy;
    end

    assign v00 = corner_val(r3_g00);
    assign v10 = corner_val(r3_g10);
    assign v01 = corner_val(r3_g01);
    assign v11 = corner_val(r3_g11);
    assign dx0 = 17'(v10) - 17'(v00);
    assign dx1 = 17'(v11) - 17'(v01);
    assign wxs = $signed({1'b0, r3_wx});

    always_ff @(posedge i_clk) begin
        r4_d0  <= 35'(dx0) * 35'(wxs);
        r4_d1  <= 35'(dx1) * 35'(wxs);
        r4_v00 <= v00;
        r4_v01 <= v01;
        r4_wy  <= r3_wy;
    end

    assign t_top = 35'(r4_v00) + (r4_d0 >>> FRAC_BITS);
    assign t_bot = 35'(r4_v01) + (r4_d1 >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        r5_top <= t_top[NOISE_W-1:0];
        r5_bot <= t_bot[NOISE_W-1:0];
        r5_wy  <= r4_wy;
    end

    assign dy = 18'(r5_bot) - 18'(r5_top);

    always_ff @(posedge i_clk) begin
        r6_prod <= 36'(dy) * 36'($signed({1'b0, r5_wy}));
        r6_top  <= r5_top;
    end

    assign t_nz    = 36'(r6_top) + (r6_prod >>> FRAC_BITS);
    assign nz      = t_nz[NOISE_W-1:0];
    assign contrib = $signed({nz, 1'b0}) >>> i_octave;

    always_ff @(posedge i_clk) begin
        o_contrib <= i_enable ? contrib : '0;
    end

endmodule

`default_nettype wire

>>> rtl/fvn_sqrt_pipe.sv
// pipelined integer square root of r * 2^16, one result bit per stage
`default_nettype none

module fvn_sqrt_pipe (
    input  wire                          i_clk,
    input  wire [fvn_pkg::UNIT_W-1:0]    i_r,
    output logic [fvn_pkg::UNIT_W-1:0]   o_r,
    output logic [fvn_pkg::UNIT_W-1:0]   o_s
);
    import fvn_pkg::*;

    localparam int SQ_W = 2 * UNIT_W;

    logic [SQ_W-1:0]   r_v   [0:SQRT_STEPS-1];
    logic [SQ_W-1:0]   r_res [0:SQRT_STEPS-1];
    logic [UNIT_W-1:0] r_rr  [0:SQRT_STEPS-1];

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++) begin : g_step
            logic [SQ_W-1:0]   cur_v, cur_res, trial, bit_w;
            logic [UNIT_W-1:0] cur_r;
            if (g == 0) begin : g_first
                assign cur_v   = SQ_W'({i_r, FRAC_BITS'(0)});
                assign cur_res = '0;
                assign cur_r   = i_r;
            end else begin : g_next
                assign cur_v   = r_v[g-1];
                assign cur_res = r_res[g-1];
                assign cur_r   = r_rr[g-1];
            end
            assign bit_w = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - g));
            assign trial = cur_res + bit_w;
            always_ff @(posedge i_clk) begin
                if (cur_v >= trial) begin
                    r_v[g]   <= cur_v - trial;
                    r_res[g] <= (cur_res >> 1) + bit_w;
                end else begin
                    r_v[g]   <= cur_v;
                    r_res[g] <= cur_res >> 1;
                end
                r_rr[g] <= cur_r;
            end
        end
    endgenerate

    assign o_s = r_res[SQRT_STEPS-1][UNIT_W-1:0];
    assign o_r = r_rr[SQRT_STEPS-1];

endmodule

`default_nettype wire

>>> rtl/fvn_post.sv
// normalization, remap, x*sqrt(x) shaping and gray byte conversion
`default_nettype none

module fvn_post (
    input  wire                               i_clk,
    input  wire signed [fvn_pkg::SUM_W-1:0]   i_sum,
    input  wire [fvn_pkg::OCT_W-1:0]          i_octaves,
    output logic [fvn_pkg::GRAY_W-1:0]        o_gray
);
    import fvn_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W + 1;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] norm, remap;
    logic [UNIT_W-1:0]        r_r;
    logic [UNIT_W-1:0]        sq_r, sq_s;
    logic [2*UNIT_W-1:0]      p_full;
    logic [UNIT_W-1:0]        r_p;
    logic [UNIT_W+7:0]        g_full;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_sum) * PROD_W'($signed({1'b0, recip_lookup(i_octaves)}));
    end

    assign norm  = r_prod >>> FRAC_BITS;
    assign remap = (norm + PROD_W'(1 << FRAC_BITS)) >>> 1;

    always_ff @(posedge i_clk) begin
        if (remap < 0) begin
            r_r <= '0;
        end else if (remap > PROD_W'(1 << FRAC_BITS)) begin
            r_r <= UNIT_W'(1 << FRAC_BITS);
        end else begin
            r_r <= remap[UNIT_W-1:0];
        end
    end

    fvn_sqrt_pipe u_sqrt (
        .i_clk (i_clk),
        .i_r   (r_r),
        .o_r   (sq_r),
        .o_s   (sq_s)
    );

    assign p_full = (2 * UNIT_W)'(sq_r) * (2 * UNIT_W)'(sq_s);

    always_ff @(posedge i_clk) begin
        r_p <= UNIT_W'(p_full >> FRAC_BITS);
    end

    assign g_full = (UNIT_W + 8)'(r_p) * (UNIT_W + 8)'(255);

    always_ff @(posedge i_clk) begin
        if ((g_full >> FRAC_BITS) > (UNIT_W + 8)'(255)) begin
            o_gray <= 8'd255;
        end else begin
            o_gray <= g_full[FRAC_BITS+GRAY_W-1:FRAC_BITS];
        end
    end

endmodule

`default_nettype wire

>>> rtl/fbm_value_noise_cloud_pixel_unit.sv
// top level: config registers, input stage, octave lanes, octave sum tree and post stage
//
// Usage: drive start high with i_pixel_x / i_pixel_y to submit one texel. busy is always
// low, so a new texel is taken every clock cycle. Each texel gives one gray byte on
// o_gray_level, qualified by o_strobe for a single cycle, in submission order.
// From the accepting edge a texel passes the input register, the octave lanes (hash
// multiplies and the blend multiplies each get their own stage), the octave adder tree,
// normalization and remap, the square root (one result bit a stage) and the shaping
// multiply and gray scaling, in that order. Throughput is one texel per cycle. All eight
// octave lanes run in parallel; octaves beyond octave_count contribute zero, but an
// octave_count of zero still runs one octave.
// Configuration: a transaction on i_cfg_valid/o_cfg_ready (ready always high) writes
// index 0 (octave_count) or index 1 (scale_log2); other indexes are dropped. Write only
// while no texel is in flight.
// Reset (i_rst_n low, synchronous) clears the pipeline valid bits and sets
// octave_count to 4 and scale_log2 to 5. The receiver cannot stall the output.
`default_nettype none

module fbm_value_noise_cloud_pixel_unit (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire [fvn_pkg::COORD_BITS-1:0]    i_pixel_x,
    input  wire [fvn_pkg::COORD_BITS-1:0]    i_pixel_y,
    output logic                             o_strobe,
    output logic [fvn_pkg::GRAY_W-1:0]       o_gray_level,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [fvn_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [fvn_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fvn_pkg::*;

    logic [OCT_W-1:0]          r_octave_count;
    logic [SCALE_W-1:0]        r_scale_log2;
    logic [OCT_W-1:0]          octaves_eff;
    logic [COORD_BITS-1:0]     r_x, r_y;
    logic [PIPE_LAT-1:0]       r_valid;
    t_contrib                  lane_contrib [0:MAX_OCTAVES-1];
    t_sum                      r_s1 [0:3];
    t_sum                      r_s2 [0:1];
    t_sum                      r_sum;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octave_count <= RST_OCTAVES;
            r_scale_log2   <= RST_SCALE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_OCTAVES: r_octave_count <= i_cfg_data[OCT_W-1:0];
                CFG_IDX_SCALE:   r_scale_log2   <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero octaves runs as one, too many as the maximum
    always_comb begin
        if (r_octave_count == '0) begin
            octaves_eff = OCT_W'(1);
        end else if (r_octave_count > OCT_W'(MAX_OCTAVES)) begin
            octaves_eff = OCT_W'(MAX_OCTAVES);
        end else begin
            octaves_eff = r_octave_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[PIPE_LAT-2:0], start & ~busy};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= i_pixel_x;
        r_y <= i_pixel_y;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_OCTAVES; g++) begin : g_lane
            fvn_octave_lane u_lane (
                .i_clk     (i_clk),
                .i_x       (r_x),
                .i_y       (r_y),
                .i_scale   (r_scale_log2),
                .i_octave  (OCT_IDX_W'(g)),
                .i_enable  (OCT_W'(g) < octaves_eff),
                .o_contrib (lane_contrib[g])
            );
        end
    endgenerate

    // registered adder tree over the eight octaves
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_s1[k] <= SUM_W'(lane_contrib[2*k]) + SUM_W'(lane_contrib[2*k+1]);
        end
        r_s2[0] <= r_s1[0] + r_s1[1];
        r_s2[1] <= r_s1[2] + r_s1[3];
        r_sum   <= r_s2[0] + r_s2[1];
    end

    fvn_post u_post (
        .i_clk     (i_clk),
        .i_sum     (r_sum),
        .i_octaves (octaves_eff),
        .o_gray    (o_gray_level)
    );

    assign o_strobe = r_valid[PIPE_LAT-1];

endmodule

`default_nettype wire
